[sv/chm_pkg.sv]
// ----------------------------------------------------------------------------
// Chained hash map package
// Types and constants shared by the front end, the request queue, the table
// engine and the top level of the hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

   localparam int KEY_W       = 31;
   localparam int VALUE_W     = 64;
   localparam int STATUS_W    = 3;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_REPLACED  = 3'd1,
      ST_REMOVED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_EXEC
   } back_state_type;

   typedef struct packed {
      logic                remove;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
   } req_item_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_status_type;

endpackage

[sv/chm_front.sv]
// ----------------------------------------------------------------------------
// Chained hash map front end
// Accepts transactions, works out the bucket as key modulo the bucket count
// with a reciprocal multiply and one correction, and pushes each transaction
// into the request queue. A credit counter keeps the queue from overflowing.
// ----------------------------------------------------------------------------
module chm_front #(
   parameter int NUM_BUCKETS = 16,
   parameter int B_W         = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_type,
   input  logic [chm_pkg::KEY_W-1:0]       req_key,
   input  logic [chm_pkg::VALUE_W-1:0]     req_value,
   input  chm_pkg::back_status_type        back_status,
   output logic                            push,
   output chm_pkg::req_item_type           push_item,
   output logic [B_W-1:0]                  push_bucket
);
   import chm_pkg::*;

   localparam logic [63:0] RECIP_FULL = 64'hFFFF_FFFF / NUM_BUCKETS;
   localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
   localparam int          REM_W      = (NUM_BUCKETS > 1) ? $clog2(2 * NUM_BUCKETS) : 1;
   localparam int          CNT_W      = $clog2(QUEUE_DEPTH + 1);

   logic                  accept;
   logic [62:0]           prod;
   logic [KEY_W-1:0]      qn;
   logic [KEY_W-1:0]      rem_full;

   logic                  s1_valid_ff, s1_valid_in;
   req_item_type          s1_item_ff;
   logic [KEY_W-1:0]      s1_quot_ff;
   logic                  s2_valid_ff, s2_valid_in;
   req_item_type          s2_item_ff;
   logic [REM_W-1:0]      s2_rem_ff, s2_rem_in;
   logic [CNT_W-1:0]      pending_ff, pending_in;

   assign busy   = reset | back_status.clearing | (pending_ff == CNT_W'(QUEUE_DEPTH));
   assign accept = start & ~busy;

   assign prod     = 63'(req_key) * 63'(RECIP);
   assign qn       = KEY_W'(s1_quot_ff * KEY_W'(NUM_BUCKETS));
   assign rem_full = s1_item_ff.key - qn;
   assign s2_rem_in = rem_full[REM_W-1:0];

   assign s1_valid_in = accept;
   assign s2_valid_in = s1_valid_ff;

   always_comb begin
      pending_in = pending_ff;
      if (accept && !back_status.pop) begin
         pending_in = pending_ff + CNT_W'(1);
      end else if (!accept && back_status.pop) begin
         pending_in = pending_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         pending_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         pending_ff  <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.remove <= req_type;
         s1_item_ff.key    <= req_key;
         s1_item_ff.value  <= req_value;
         s1_quot_ff        <= prod[62:32];
      end
      s2_item_ff <= s1_item_ff;
      s2_rem_ff  <= s2_rem_in;
   end

   always_comb begin
      if (s2_rem_ff >= REM_W'(NUM_BUCKETS)) begin
         push_bucket = B_W'(s2_rem_ff - REM_W'(NUM_BUCKETS));
      end else begin
         push_bucket = B_W'(s2_rem_ff);
      end
   end

   assign push      = s2_valid_ff;
   assign push_item = s2_item_ff;

endmodule

[sv/chm_queue.sv]
// ----------------------------------------------------------------------------
// Chained hash map request queue
// A small first-in first-out buffer between the front end and the table
// engine. The front end never pushes into a full queue.
// ----------------------------------------------------------------------------
module chm_queue #(
   parameter int WIDTH = 100
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head_data
);
   import chm_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/chm_back.sv]
// ----------------------------------------------------------------------------
// Chained hash map table engine
// Holds the slot tables, one row per bucket. Clears the valid bits after
// reset, then takes one transaction at a time: reads the bucket row, matches
// keys, writes the row back and reports status and the table-empty flag.
// ----------------------------------------------------------------------------
module chm_back #(
   parameter int NUM_BUCKETS      = 16,
   parameter int SLOTS_PER_BUCKET = 4,
   parameter int B_W              = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  chm_pkg::req_item_type           q_item,
   input  logic [B_W-1:0]                  q_bucket,
   output chm_pkg::back_status_type        back_status,
   output logic                            rsp_strobe,
   output logic [chm_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_table_empty
);
   import chm_pkg::*;

   localparam int S     = SLOTS_PER_BUCKET;
   localparam int SL_W  = (S > 1) ? $clog2(S) : 1;
   localparam int CNT_W = $clog2(NUM_BUCKETS * S + 1);

   logic [S-1:0]                  valid_mem [NUM_BUCKETS];
   logic [S-1:0][KEY_W-1:0]       key_mem   [NUM_BUCKETS];
   logic [S-1:0][VALUE_W-1:0]     value_mem [NUM_BUCKETS];

   back_state_type                state_ff, state_in;
   logic [B_W-1:0]                clr_ptr_ff, clr_ptr_in;
   req_item_type                  cur_item_ff;
   logic [B_W-1:0]                cur_bucket_ff;
   logic [S-1:0]                  rd_valid_ff;
   logic [S-1:0][KEY_W-1:0]       rd_key_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          rsp_strobe_ff;
   status_type                    rsp_status_ff, status;
   logic                          rsp_table_empty_ff;

   logic                          clearing, pop, exec;
   logic [S-1:0]                  hit;
   logic                          hit_any, free_any;
   logic [SL_W-1:0]               hit_idx, free_idx, wslot;
   logic                          valid_we, key_we, value_we;
   logic [B_W-1:0]                valid_waddr;
   logic [S-1:0]                  valid_wdata, new_row;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_CLEAR: begin
            if (clr_ptr_ff == B_W'(NUM_BUCKETS - 1)) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_IDLE: begin
            if (!q_empty) begin
               state_in = BACK_EXEC;
            end
         end
         BACK_EXEC: begin
            state_in = BACK_IDLE;
         end
         default: begin
            state_in = BACK_CLEAR;
         end
      endcase
   end

   always_comb begin
      clearing = 1'b0;
      pop      = 1'b0;
      exec     = 1'b0;
      unique case (state_ff)
         BACK_CLEAR: clearing = 1'b1;
         BACK_IDLE:  pop      = ~q_empty;
         BACK_EXEC:  exec     = 1'b1;
         default:    clearing = 1'b0;
      endcase
   end

   assign back_status.clearing = clearing;
   assign back_status.pop      = pop;
   assign clr_ptr_in           = clr_ptr_ff + B_W'(1);

   always_comb begin
      hit      = '0;
      hit_idx  = '0;
      free_idx = '0;
      for (int s = 0; s < S; s++) begin
         hit[s] = rd_valid_ff[s] && (rd_key_ff[s] == cur_item_ff.key);
      end
      for (int s = S - 1; s >= 0; s--) begin
         if (hit[s]) begin
            hit_idx = SL_W'(s);
         end
         if (!rd_valid_ff[s]) begin
            free_idx = SL_W'(s);
         end
      end
      hit_any  = |hit;
      free_any = ~&rd_valid_ff;
   end

   always_comb begin
      status   = ST_FULL;
      new_row  = rd_valid_ff;
      count_in = count_ff;
      key_we   = 1'b0;
      value_we = 1'b0;
      wslot    = hit_idx;
      if (exec) begin
         priority if (cur_item_ff.remove && hit_any) begin
            status           = ST_REMOVED;
            new_row[hit_idx] = 1'b0;
            count_in         = count_ff - CNT_W'(1);
         end else if (cur_item_ff.remove) begin
            status = ST_NOT_FOUND;
         end else if (hit_any) begin
            status   = ST_REPLACED;
            value_we = 1'b1;
         end else if (free_any) begin
            status            = ST_INSERTED;
            new_row[free_idx] = 1'b1;
            count_in          = count_ff + CNT_W'(1);
            key_we            = 1'b1;
            value_we          = 1'b1;
            wslot             = free_idx;
         end else begin
            status = ST_FULL;
         end
      end
   end

   assign valid_we    = clearing | exec;
   assign valid_waddr = clearing ? clr_ptr_ff : cur_bucket_ff;
   assign valid_wdata = clearing ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (valid_we) begin
         valid_mem[valid_waddr] <= valid_wdata;
      end
      if (key_we) begin
         key_mem[cur_bucket_ff][wslot] <= cur_item_ff.key;
      end
      if (value_we) begin
         value_mem[cur_bucket_ff][wslot] <= cur_item_ff.value;
      end
      if (pop) begin
         rd_valid_ff   <= valid_mem[q_bucket];
         rd_key_ff     <= key_mem[q_bucket];
         cur_item_ff   <= q_item;
         cur_bucket_ff <= q_bucket;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_CLEAR;
         clr_ptr_ff    <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ptr_ff    <= clr_ptr_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= exec;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_status_ff      <= status;
         rsp_table_empty_ff <= (count_in == '0);
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_table_empty = rsp_table_empty_ff;

endmodule

[sv/chained_hash_map_insert_remove.sv]
// ----------------------------------------------------------------------------
// Chained hash map with insert and remove
// Keyed table with bounded buckets chosen by key modulo the bucket count.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge with start high and busy low;
// it carries req_type (0 insert or replace, 1 remove), req_key and req_value.
// Every transaction yields one result: rsp_status and rsp_table_empty are
// valid for the single cycle in which rsp_strobe is high. The receiver cannot
// stall, so results never back up into the block.
// A transaction passes the front-end stages and the queue; the strobe rises
// once the table engine has read and executed it. The engine takes one
// transaction at a time and no new one before the last is done: in its idle
// state it pops the queue and reads the bucket row from the slot tables, in
// its execute state it matches keys and writes the row back. The front end
// computes the bucket in two pipeline stages and keeps up to four transactions
// in flight ahead of the engine; busy rises when four are waiting. After reset,
// busy stays high while all valid bits are cleared; the table then starts empty.
// ----------------------------------------------------------------------------
module chained_hash_map_insert_remove #(
   parameter int NUM_BUCKETS      = 16,
   parameter int SLOTS_PER_BUCKET = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_type,
   input  logic [chm_pkg::KEY_W-1:0]       req_key,
   input  logic [chm_pkg::VALUE_W-1:0]     req_value,
   output logic                            rsp_strobe,
   output logic [chm_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_table_empty
);
   import chm_pkg::*;

   localparam int B_W     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int ITEM_W  = $bits(req_item_type);
   localparam int ENTRY_W = B_W + ITEM_W;

   back_status_type        back_status;
   logic                   push;
   req_item_type           push_item;
   logic [B_W-1:0]         push_bucket;
   logic                   q_empty;
   logic [ENTRY_W-1:0]     q_head;
   req_item_type           q_item;
   logic [B_W-1:0]         q_bucket;

   chm_front #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .B_W         (B_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_type    (req_type),
      .req_key     (req_key),
      .req_value   (req_value),
      .back_status (back_status),
      .push        (push),
      .push_item   (push_item),
      .push_bucket (push_bucket)
   );

   chm_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_bucket, push_item}),
      .pop       (back_status.pop),
      .empty     (q_empty),
      .head_data (q_head)
   );

   assign q_item   = req_item_type'(q_head[ITEM_W-1:0]);
   assign q_bucket = q_head[ENTRY_W-1:ITEM_W];

   chm_back #(
      .NUM_BUCKETS      (NUM_BUCKETS),
      .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
      .B_W              (B_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_item          (q_item),
      .q_bucket        (q_bucket),
      .back_status     (back_status),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_table_empty (rsp_table_empty)
   );

endmodule

[sv/chm_checker.sv]
// ----------------------------------------------------------------------------
// Chained hash map port checker
// Watches the top-level ports for results that the table engine can never
// produce and for a missing busy indication after reset.
// ----------------------------------------------------------------------------
module chm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            req_type,
   input logic [chm_pkg::KEY_W-1:0]       req_key,
   input logic [chm_pkg::VALUE_W-1:0]     req_value,
   input logic                            rsp_strobe,
   input logic [chm_pkg::STATUS_W-1:0]    rsp_status,
   input logic                            rsp_table_empty
);
   import chm_pkg::*;

   logic unused_inputs;
   assign unused_inputs = start ^ req_type ^ (^req_key) ^ (^req_value);

   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Two transactions completed in consecutive cycles.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == ST_INSERTED || rsp_status == ST_REPLACED ||
                      rsp_status == ST_REMOVED || rsp_status == ST_NOT_FOUND ||
                      rsp_status == ST_FULL))
      else $error("Result carries an undefined status code.");

   a_not_empty_after_store: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_INSERTED || rsp_status == ST_REPLACED))
         |-> !rsp_table_empty)
      else $error("Table reported empty after a key was stored.");

   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) |-> busy)
      else $error("Block not busy in the cycle after reset.");

   a_quiet_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_strobe)
      else $error("Result strobe in the cycle after reset.");

endmodule

bind chained_hash_map_insert_remove chm_checker u_chm_checker (.*);
